@@ hdl/scope_minmax_decimator_trigger_defines.svh @@
// Assertion macros for the scope min/max decimator.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef SCOPE_MINMAX_DECIMATOR_TRIGGER_DEFINES_SVH
`define SCOPE_MINMAX_DECIMATOR_TRIGGER_DEFINES_SVH
`ifndef SYNTHESIS
`define SMDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smdt assertion failed");
`define SMDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smdt assertion failed");
`else
`define SMDT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMDT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/smdt_pkg.sv @@
package smdt_pkg;

	localparam int STORE_DEPTH_DEF   = 8192;
	localparam int SCREEN_WIDTH_DEF  = 512;
	localparam int SCREEN_HEIGHT_DEF = 512;

	localparam int ACT_W      = 2;
	localparam int SAMPLE_W   = 16;
	localparam int COL_W      = 9;
	localparam int VIEW_W     = 13;
	localparam int ROW_W      = 10;
	localparam int KIND_W     = 2;
	localparam int MODE_W     = 2;
	localparam int SPC_W      = 16;
	localparam int ZOOM_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// request actions
	localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	// trigger modes
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RISING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FALLING = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_COLUMN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_ZOOM      = 2'd2;

	// fill kinds
	localparam logic [KIND_W-1:0] FILL_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] FILL_BOTTOM = 2'd1;
	localparam logic [KIND_W-1:0] FILL_TOP    = 2'd2;

	// reset values
	localparam logic [MODE_W-1:0] MODE_RST          = MODE_RISING;
	localparam logic [SPC_W-1:0]  SPC_RST           = 16'd2;
	localparam logic [ZOOM_W-1:0] ZOOM_RST          = 12'd256;
	localparam logic [SPC_W-1:0]  LEFT_RST          = 16'd2;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

	typedef struct packed {
		logic [ACT_W-1:0]           action;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [COL_W-1:0]           column;
	} req_t;

	typedef struct packed {
		logic              trigger_found;
		logic [VIEW_W-1:0] view_start;
		logic [ROW_W-1:0]  top_row;
		logic [ROW_W-1:0]  bottom_row;
		logic [KIND_W-1:0] fill_kind;
		logic [ROW_W-1:0]  fill_from;
		logic [ROW_W-1:0]  fill_to;
	} res_t;

	typedef struct packed {
		logic push;
		logic rd_start;
		logic rd_mul;
		logic loc_start;
		logic loc_run;
		logic loc_end;
		logic out_load;
		logic out_loc;
	} smdt_cmd_t;

	typedef struct packed {
		logic loc_hit;
		logic loc_exhausted;
	} smdt_stat_t;

endpackage

@@ hdl/scope_minmax_decimator_trigger.sv @@
// Oscilloscope min/max decimator with zero-crossing trigger.
// Requests arrive on req_valid/req_ready/req_data; results leave on
// res_valid/res_ready/res_data. Configuration is written through cfg_we,
// cfg_index and cfg_wdata in any cycle with no wait; write it only while idle.
// A push request is taken every cycle while idle and gives no result: the
// min/max compare and, on a column close, the ring-store write happen at
// the accepting edge. A read-column request registers the store read, then
// the zoom multiply, then the scaled rows once the result register is free;
// the next request is taken after that. A locate request walks the store
// backwards one entry a cycle through the single read port of each store,
// ending at a match or after the whole store; with the trigger off, no search.
// Reset restores the registers to their defaults; the store needs no
// clearing pass, since a write pointer and a wrap flag mark the entries that
// were never written, which read as zero.
// The result register holds one result. While the receiver stalls, pushes
// are still taken; a locate or read waits at its last step for the register.
module scope_minmax_decimator_trigger import smdt_pkg::*; #(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res_data
);

	smdt_cmd_t  cmd;
	smdt_stat_t stat;

	// sequence requests, own the result handshake
	smdt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req_data.action),
		.req_ready  (req_ready),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.stat       (stat),
		.cmd        (cmd)
	);

	// hold the stores, registers, search and row scaling
	smdt_datapath #(
		.STORE_DEPTH   (STORE_DEPTH),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_data),
		.cmd       (cmd),
		.stat      (stat),
		.res_data  (res_data)
	);

endmodule

@@ hdl/smdt_datapath.sv @@
module smdt_datapath import smdt_pkg::*; #(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  req_t                  req_data,
	input  smdt_cmd_t             cmd,
	output smdt_stat_t            stat,
	output res_t                  res_data
);

	localparam int IW   = $clog2(STORE_DEPTH);
	localparam int IW1  = IW + 1;
	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int ROWW = $clog2(SCREEN_HEIGHT + 1);
	localparam int PW   = 24 + ROWW;
	localparam int BACK = SCREEN_WIDTH % STORE_DEPTH;
	localparam logic [IW:0]     DEPTH_W = IW1'(STORE_DEPTH);
	localparam logic [IW-1:0]   LAST    = IW'(STORE_DEPTH - 1);
	localparam logic [IW-1:0]   BACK_I  = IW'(BACK);
	localparam logic [CW-1:0]   DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [ROWW-1:0] MID     = ROWW'(SCREEN_HEIGHT / 2);
	localparam logic [ROWW-1:0] FULL_H  = ROWW'(SCREEN_HEIGHT);

	logic [MODE_W-1:0] mode_q;
	logic [SPC_W-1:0]  spc_q;
	logic [ZOOM_W-1:0] zoom_q;

	logic [IW-1:0] wi_q;
	logic          full_q;
	logic signed [SAMPLE_W-1:0] run_min_q, run_max_q;
	logic [SPC_W-1:0] left_q;

	logic [IW-1:0] start_q, from_q, pos_q, pos_s1;
	logic [CW-1:0] cnt_q;
	logic          found_q;
	logic          issued_s1;

	logic signed [SAMPLE_W-1:0] mem_min [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] mem_max [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_min_s1, rd_max_s1;
	logic vmin_s1, vmax_s1;
	logic signed [28:0] p_top_s2, p_bot_s2;
	res_t res_q;
	res_t res_d;

	logic signed [SAMPLE_W-1:0] samp, new_min, new_max, min_v, max_v;
	logic close_col, wr_en, issue, hit;
	logic [IW-1:0] wi_next, prev_pos, col_idx, from_calc, addr_min, addr_max;
	logic [IW:0]   col_sum;
	logic min_ok, max_ok;
	logic [ROWW-1:0] top_r, bot_r, from_r, to_r;
	logic [KIND_W-1:0] kind;

	// Row of one scaled sample: floor(H * (2^23 - p) / 2^24), clamped to 0..H.
	function automatic logic [ROWW-1:0] row_of(input logic signed [28:0] p);
		logic signed [29:0] d;
		logic [PW-1:0] prod;
		d = 30'sd8388608 - p;
		prod = PW'(d[23:0]) * PW'(SCREEN_HEIGHT);
		if (d < 30'sd0)
			return '0;
		else if (d >= 30'sd16777216)
			return FULL_H;
		else
			return prod[PW-1:24];
	endfunction

	// sample folding
	assign samp      = req_data.sample_value;
	assign new_min   = (samp < run_min_q) ? samp : run_min_q;
	assign new_max   = (samp > run_max_q) ? samp : run_max_q;
	assign close_col = (left_q <= SPC_W'(1));
	assign wr_en     = cmd.push && close_col;
	assign wi_next   = (wi_q == LAST) ? '0 : wi_q + IW'(1);

	// addresses
	assign prev_pos  = (pos_q == '0) ? LAST : pos_q - IW'(1);
	assign col_sum   = {1'b0, start_q} + IW1'(1) + IW1'(req_data.column);
	assign col_idx   = (col_sum >= DEPTH_W) ? IW'(col_sum - DEPTH_W) : IW'(col_sum);
	assign from_calc = (wi_q >= BACK_I) ? wi_q - BACK_I
		: IW'({1'b0, wi_q} + DEPTH_W - IW1'(BACK_I));
	assign addr_min  = cmd.loc_run ? prev_pos : col_idx;
	assign addr_max  = cmd.loc_run ? pos_q : col_idx;
	// entries beyond the fill point were never written and read as zero
	assign min_ok    = full_q || (addr_min < wi_q);
	assign max_ok    = full_q || (addr_max < wi_q);

	// search compare
	assign min_v = vmin_s1 ? rd_min_s1 : '0;
	assign max_v = vmax_s1 ? rd_max_s1 : '0;
	assign issue = cmd.loc_run && (cnt_q != DEPTH_C);

	always_comb begin
		hit = 1'b0;
		if (issued_s1 && mode_q != MODE_OFF) begin
			if (mode_q == MODE_RISING)
				hit = (min_v <= 0) && (max_v > 0);
			else
				hit = (min_v > 0) && (max_v <= 0);
		end
	end

	assign stat.loc_hit       = hit;
	assign stat.loc_exhausted = (mode_q == MODE_OFF) || ((cnt_q == DEPTH_C) && !issued_s1);

	// column rows
	always_comb begin
		top_r  = row_of(p_top_s2);
		bot_r  = row_of(p_bot_s2);
		kind   = FILL_NONE;
		from_r = '0;
		to_r   = '0;
		if (p_top_s2 > 0 && p_bot_s2 > 0) begin
			kind   = FILL_BOTTOM;
			from_r = bot_r;
			to_r   = MID;
		end else if (p_top_s2 <= 0 && p_bot_s2 <= 0) begin
			kind   = FILL_TOP;
			from_r = MID;
			to_r   = top_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RST;
			spc_q     <= SPC_RST;
			zoom_q    <= ZOOM_RST;
			wi_q      <= '0;
			full_q    <= 1'b0;
			run_min_q <= SAMPLE_MIN;
			run_max_q <= SAMPLE_MAX;
			left_q    <= LEFT_RST;
			start_q   <= '0;
			from_q    <= '0;
			pos_q     <= '0;
			pos_s1    <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			issued_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TRIGGER_MODE:       mode_q <= cfg_wdata[MODE_W-1:0];
					CFG_SAMPLES_PER_COLUMN: spc_q  <= cfg_wdata[SPC_W-1:0];
					CFG_VERTICAL_ZOOM:      zoom_q <= cfg_wdata[ZOOM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.push) begin
				if (close_col) begin
					wi_q      <= wi_next;
					if (wi_q == LAST)
						full_q <= 1'b1;
					run_min_q <= SAMPLE_MAX;
					run_max_q <= SAMPLE_MIN;
					left_q    <= (spc_q == '0) ? SPC_W'(1) : spc_q;
				end else begin
					run_min_q <= new_min;
					run_max_q <= new_max;
					left_q    <= left_q - SPC_W'(1);
				end
			end
			if (cmd.loc_start) begin
				from_q <= from_calc;
				pos_q  <= from_calc;
				cnt_q  <= '0;
			end else if (issue) begin
				pos_q <= prev_pos;
				cnt_q <= cnt_q + CW'(1);
			end
			issued_s1 <= issue;
			if (issue)
				pos_s1 <= pos_q;
			if (cmd.loc_end) begin
				found_q <= hit;
				start_q <= hit ? pos_s1 : from_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_min[wi_q] <= new_min;
			mem_max[wi_q] <= new_max;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_start || cmd.loc_run) begin
			rd_min_s1 <= mem_min[addr_min];
			rd_max_s1 <= mem_max[addr_max];
			vmin_s1   <= min_ok;
			vmax_s1   <= max_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_mul) begin
			p_top_s2 <= $signed({1'b0, zoom_q}) * max_v;
			p_bot_s2 <= $signed({1'b0, zoom_q}) * min_v;
		end
	end

	// assemble the result: a locate leaves the row fields at zero
	always_comb begin
		res_d            = '0;
		res_d.view_start = VIEW_W'(start_q);
		if (cmd.out_loc) begin
			res_d.trigger_found = found_q;
		end else begin
			res_d.top_row    = ROW_W'(top_r);
			res_d.bottom_row = ROW_W'(bot_r);
			res_d.fill_kind  = kind;
			res_d.fill_from  = ROW_W'(from_r);
			res_d.fill_to    = ROW_W'(to_r);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			res_q <= res_d;
	end

	assign res_data = res_q;

endmodule

@@ hdl/smdt_ctrl.sv @@
`include "scope_minmax_decimator_trigger_defines.svh"

module smdt_ctrl import smdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [ACT_W-1:0] req_action,
	output logic             req_ready,
	input  logic             res_ready,
	output logic             res_valid,
	input  smdt_stat_t       stat,
	output smdt_cmd_t        cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_RD_MEM   = 3'd1;
	localparam logic [2:0] S_RD_MUL   = 3'd2;
	localparam logic [2:0] S_LOC_RUN  = 3'd3;
	localparam logic [2:0] S_LOC_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic       full_q;
	logic       accept, slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !full_q || res_ready;
	assign res_valid = full_q;

	always_comb begin
		cmd           = '0;
		cmd.push      = accept && (req_action == ACT_PUSH);
		cmd.rd_start  = accept && (req_action == ACT_READ);
		cmd.loc_start = accept && (req_action == ACT_LOCATE);
		cmd.rd_mul    = (state_q == S_RD_MEM);
		cmd.loc_run   = (state_q == S_LOC_RUN);
		cmd.loc_end   = cmd.loc_run && (stat.loc_hit || stat.loc_exhausted);
		cmd.out_loc   = (state_q == S_LOC_DONE);
		cmd.out_load  = slot_free && ((state_q == S_RD_MUL) || (state_q == S_LOC_DONE));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.rd_start)
					state_d = S_RD_MEM;
				else if (cmd.loc_start)
					state_d = S_LOC_RUN;
			end
			S_RD_MEM:   state_d = S_RD_MUL;
			S_RD_MUL:   if (cmd.out_load) state_d = S_IDLE;
			S_LOC_RUN:  if (cmd.loc_end) state_d = S_LOC_DONE;
			S_LOC_DONE: if (cmd.out_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				full_q <= 1'b1;
			else if (res_ready)
				full_q <= 1'b0;
		end
	end

	`SMDT_ASSERT_NXT(a_rd_mul_next, clk, arst_n, cmd.rd_mul, state_q == S_RD_MUL)
	`SMDT_ASSERT_NXT(a_loc_start_run, clk, arst_n, cmd.loc_start, state_q == S_LOC_RUN)
	`SMDT_ASSERT_NXT(a_load_shows, clk, arst_n, cmd.out_load, res_valid)
	`SMDT_ASSERT_IMP(a_rise_from_load, clk, arst_n, $rose(res_valid), $past(state_q == S_RD_MUL || state_q == S_LOC_DONE))

endmodule

@@ tb/sv/testbench.sv @@
module testbench import smdt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = STORE_DEPTH_DEF;
	localparam int WIDTH  = SCREEN_WIDTH_DEF;
	localparam int HEIGHT = SCREEN_HEIGHT_DEF;

	// The package names only three actions; the fourth code is ignored by the block.
	localparam logic [ACT_W-1:0]  ACT_NONE      = 2'd3;
	// Mode code three is undocumented in the package and acts as a falling trigger.
	localparam logic [MODE_W-1:0] MODE_FALL_ALT = 2'd3;

	// Pushes complete at the accepting edge and a read or locate is done once its
	// result has been taken, so this many idle cycles leave the block quiet.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int MAX_REPORTS   = 10;

	localparam longint HALF_NUM = longint'(HEIGHT) * 64'd8388608;
	localparam longint FULL_NUM = longint'(HEIGHT) * 64'd16777216;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req_data = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res_data;

	scope_minmax_decimator_trigger DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#(50_000_000);
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block: ring store, folding state, view start and
	// the three registers. Updated once per accepted request, in order.
	// ------------------------------------------------------------------
	int                pair_min [DEPTH];
	int                pair_max [DEPTH];
	int unsigned       wr_ptr;
	int                fold_min;
	int                fold_max;
	int unsigned       fold_left;
	int unsigned       view_base;
	logic [MODE_W-1:0] trig_mode;
	logic [SPC_W-1:0]  fold_len;
	logic [ZOOM_W-1:0] zoom;

	res_t due_results [$];

	int mismatches = 0;
	int n_checked  = 0;
	int n_push     = 0;
	int n_pairs    = 0;
	int n_locate   = 0;
	int n_found    = 0;
	int n_read     = 0;
	int n_ignored  = 0;
	int n_settings = 0;

	// sender burst state and the triangle wave that feeds part of the samples
	int burst_left = 0;
	int wave_val   = 0;
	int wave_step  = 1200;

	// receiver stall pattern
	int stall_mode = 0;
	int stall_cnt  = 0;

	function automatic void reset_shadow();
		foreach (pair_min[i]) begin
			pair_min[i] = 0;
			pair_max[i] = 0;
		end
		wr_ptr    = 0;
		fold_min  = -32768;
		fold_max  = 32767;
		fold_left = 2;
		view_base = 0;
		trig_mode = MODE_RST;
		fold_len  = SPC_RST;
		zoom      = ZOOM_RST;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_TRIGGER_MODE:       trig_mode = val[MODE_W-1:0];
			CFG_SAMPLES_PER_COLUMN: fold_len  = val[SPC_W-1:0];
			CFG_VERTICAL_ZOOM:      zoom      = val[ZOOM_W-1:0];
			default: ;
		endcase
	endfunction

	// Unrounded screen row times 2^24 for a stored sample at the current zoom.
	function automatic longint row_scaled(int s);
		return HALF_NUM - longint'(zoom) * longint'(s) * longint'(HEIGHT);
	endfunction

	function automatic logic [ROW_W-1:0] row_clamp(longint num);
		if (num < 0)
			return '0;
		if (num >= FULL_NUM)
			return ROW_W'(HEIGHT);
		return ROW_W'(num >>> 24);
	endfunction

	// Advance the shadow by one request and work out the result it produces.
	task automatic scope_response(input req_t r, output bit gives, output res_t res);
		int          s;
		int unsigned start_pos;
		int unsigned pos;
		int unsigned prev;
		int unsigned idx;
		int unsigned n;
		bit          hit;
		bit          found;
		longint      nt;
		longint      nb;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;

		s     = int'($signed(r.sample_value));
		res   = '0;
		gives = 1'b0;
		case (r.action)
			ACT_PUSH: begin
				n_push++;
				if (s < fold_min)
					fold_min = s;
				if (s > fold_max)
					fold_max = s;
				if (fold_left <= 1) begin
					// close the column: store the pair and restart the fold inverted
					pair_min[wr_ptr] = fold_min;
					pair_max[wr_ptr] = fold_max;
					wr_ptr    = (wr_ptr + 1) % DEPTH;
					fold_max  = -32768;
					fold_min  = 32767;
					fold_left = (fold_len == 0) ? 1 : fold_len;
					n_pairs++;
				end else begin
					fold_left--;
				end
			end
			ACT_LOCATE: begin
				n_locate++;
				start_pos = (wr_ptr + DEPTH - (WIDTH % DEPTH)) % DEPTH;
				pos   = start_pos;
				found = 1'b0;
				if (trig_mode != MODE_OFF) begin
					for (n = 0; n < DEPTH && !found; n++) begin
						prev = (pos + DEPTH - 1) % DEPTH;
						if (trig_mode == MODE_RISING)
							hit = pair_min[prev] <= 0 && pair_max[pos] > 0;
						else
							hit = pair_min[prev] > 0 && pair_max[pos] <= 0;
						if (hit)
							found = 1'b1;
						else
							pos = (pos + DEPTH - 1) % DEPTH;
					end
				end
				view_base = found ? pos : start_pos;
				n_found += found;
				res.trigger_found = found;
				res.view_start    = VIEW_W'(view_base);
				gives = 1'b1;
			end
			ACT_READ: begin
				n_read++;
				idx    = (view_base + 1 + r.column) % DEPTH;
				nt     = row_scaled(pair_max[idx]);
				nb     = row_scaled(pair_min[idx]);
				top    = row_clamp(nt);
				bottom = row_clamp(nb);
				res.view_start = VIEW_W'(view_base);
				res.top_row    = top;
				res.bottom_row = bottom;
				if (nb < HALF_NUM && nt < HALF_NUM) begin
					// whole column above the midline
					res.fill_kind = FILL_BOTTOM;
					res.fill_from = bottom;
					res.fill_to   = ROW_W'(HEIGHT / 2);
				end else if (nb >= HALF_NUM && nt >= HALF_NUM) begin
					res.fill_kind = FILL_TOP;
					res.fill_from = ROW_W'(HEIGHT / 2);
					res.fill_to   = top;
				end
				gives = 1'b1;
			end
			default: n_ignored++;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Result side: a stall pattern that switches at random between three
	// modes (always ready, coin flip, mostly stalled), and a checker that
	// pops the oldest expectation for each accepted result.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_cnt  = $urandom_range(40, 300);
		end else begin
			stall_cnt--;
		end
		case (stall_mode)
			0:       res_ready <= 1'b1;
			1:       res_ready <= 1'($urandom_range(0, 1));
			default: res_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic check_result(input res_t got);
		res_t want;
		bit   bad;

		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: result with nothing outstanding: found=%0d view=%0d top=%0d",
					$realtime, got.trigger_found, got.view_start, got.top_row);
			return;
		end
		want = due_results.pop_front();
		n_checked++;
		bad = (got.trigger_found !== want.trigger_found) ||
			(got.view_start !== want.view_start) ||
			(got.top_row !== want.top_row) ||
			(got.bottom_row !== want.bottom_row) ||
			(got.fill_kind !== want.fill_kind) ||
			(got.fill_from !== want.fill_from) ||
			(got.fill_to !== want.fill_to);
		if (bad) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display({"%0t: result %0d mismatch\n",
					"  expected found=%0d view=%0d top=%0d bottom=%0d kind=%0d fill=%0d..%0d\n",
					"  actual   found=%0d view=%0d top=%0d bottom=%0d kind=%0d fill=%0d..%0d"},
					$realtime, n_checked,
					want.trigger_found, want.view_start, want.top_row, want.bottom_row,
					want.fill_kind, want.fill_from, want.fill_to,
					got.trigger_found, got.view_start, got.top_row, got.bottom_row,
					got.fill_kind, got.fill_from, got.fill_to);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res_data);
	end

	// ------------------------------------------------------------------
	// Request side. Every task is entered and left just after a falling
	// edge, so inputs only ever change there.
	// ------------------------------------------------------------------

	// Present one request, hold it until accepted, then update the shadow.
	// The sender runs in bursts; a gap is only opened between bursts.
	task automatic send_request(input req_t r, input bit typed, input res_t typed_res);
		bit   gives;
		res_t pred;
		int   gap;

		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid = 1'b1;
		req_data  = r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		scope_response(r, gives, pred);
		// rows with a hand-written answer override the shadow's answer
		if (gives)
			due_results.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Drop valid, drain every outstanding result, then let the block settle.
	task automatic wait_idle();
		req_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		apply_cfg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mix of a triangle wave (regular zero crossings), full-range noise,
	// the extremes and values right around zero.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				wave_val += wave_step;
				if (wave_val > 32767) begin
					wave_val  = 32767;
					wave_step = -wave_step;
				end else if (wave_val < -32768) begin
					wave_val  = -32768;
					wave_step = -wave_step;
				end
				return SAMPLE_W'(wave_val);
			end
			4, 5, 6: return SAMPLE_W'($urandom);
			7: begin
				case ($urandom_range(0, 4))
					0:       return SAMPLE_MIN;
					1:       return SAMPLE_MAX;
					2:       return -16'sd1;
					3:       return 16'sd1;
					default: return 16'sd0;
				endcase
			end
			8:       return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
			default: return 16'sd0;
		endcase
	endfunction

	// One well-formed stretch: pushes, maybe a locate, a run of column reads,
	// and now and then an ignored action code. Ignored requests are not counted.
	task automatic run_sequence(output int counted);
		req_t r;
		int   n_rd;
		int   col;
		bit   walk;

		counted = 0;
		repeat ($urandom_range(1, 24)) begin
			r.action       = ACT_PUSH;
			r.sample_value = pick_sample();
			r.column       = COL_W'($urandom);
			send_request(r, 1'b0, '0);
			counted++;
		end
		if ($urandom_range(0, 3) == 0) begin
			r.action       = ACT_LOCATE;
			r.sample_value = SAMPLE_W'($urandom);
			r.column       = COL_W'($urandom);
			send_request(r, 1'b0, '0);
			counted++;
		end
		n_rd = $urandom_range(0, 6);
		walk = 1'($urandom_range(0, 1));
		col  = $urandom_range(0, 511);
		repeat (n_rd) begin
			r.action       = ACT_READ;
			r.sample_value = SAMPLE_W'($urandom);
			// either walk across the screen or jump around
			r.column       = walk ? COL_W'(col) : COL_W'($urandom);
			col++;
			send_request(r, 1'b0, '0);
			counted++;
		end
		if ($urandom_range(0, 15) == 0) begin
			r.action       = ACT_NONE;
			r.sample_value = SAMPLE_W'($urandom);
			r.column       = COL_W'($urandom);
			send_request(r, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Directed plan: requests and register writes in order. Only results
	// that follow straight from reset carry a hand-written answer.
	// ------------------------------------------------------------------
	typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		req_t                  req;
		bit                    typed;
		res_t                  want;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
	} plan_step_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] mode;
		logic [CFG_DATA_W-1:0] spc;
		logic [CFG_DATA_W-1:0] zoom;
	} setting_t;

	plan_step_t plan [$];
	setting_t   settings [6];

	function automatic plan_step_t req_step(logic [ACT_W-1:0] act, logic signed [SAMPLE_W-1:0] smp,
			logic [COL_W-1:0] col);
		plan_step_t st;
		st.kind             = STEP_REQ;
		st.req.action       = act;
		st.req.sample_value = smp;
		st.req.column       = col;
		st.typed            = 1'b0;
		st.want             = '0;
		st.cfg_idx          = '0;
		st.cfg_val          = '0;
		return st;
	endfunction

	function automatic plan_step_t typed_step(logic [ACT_W-1:0] act, logic [COL_W-1:0] col,
			res_t want);
		plan_step_t st;
		st       = req_step(act, 16'sd0, col);
		st.typed = 1'b1;
		st.want  = want;
		return st;
	endfunction

	function automatic plan_step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_step_t st;
		st         = req_step(ACT_NONE, 16'sd0, '0);
		st.kind    = STEP_CFG;
		st.cfg_idx = idx;
		st.cfg_val = val;
		return st;
	endfunction

	initial begin
		int   counted;
		int   got;
		req_t r;

		reset_shadow();

		// Empty store after reset: every pair reads as zero, which lands exactly
		// on the midline, so both rows are half height and the fill is degenerate.
		plan.push_back(typed_step(ACT_READ, 9'd0,
			'{1'b0, 13'd0, 10'd256, 10'd256, FILL_TOP, 10'd256, 10'd256}));
		// rising search over an all-zero store finds nothing: view start is one
		// screen behind the write position
		plan.push_back(typed_step(ACT_LOCATE, 9'd0,
			'{1'b0, 13'd7680, 10'd0, 10'd0, FILL_NONE, 10'd0, 10'd0}));
		// the last column wraps round the end of the store
		plan.push_back(typed_step(ACT_READ, 9'd511,
			'{1'b0, 13'd7680, 10'd256, 10'd256, FILL_TOP, 10'd256, 10'd256}));
		plan.push_back(req_step(ACT_NONE, SAMPLE_MIN, 9'd511));
		// five pairs: full range, straddling zero, positive, floor, ceiling
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MAX, 9'd0));
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MIN, 9'd0));
		plan.push_back(req_step(ACT_PUSH, 16'sd0, 9'd0));
		plan.push_back(req_step(ACT_PUSH, -16'sd1, 9'd0));
		plan.push_back(req_step(ACT_PUSH, 16'sd1, 9'd0));
		plan.push_back(req_step(ACT_PUSH, 16'sd1, 9'd0));
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MIN, 9'd0));
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MIN, 9'd0));
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MAX, 9'd0));
		plan.push_back(req_step(ACT_PUSH, SAMPLE_MAX, 9'd0));
		plan.push_back(req_step(ACT_LOCATE, 16'sd0, 9'd0));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd0));
		// upper write bits must be dropped: this selects falling
		plan.push_back(cfg_step(CFG_TRIGGER_MODE, 16'hFFFC | 16'(MODE_FALLING)));
		plan.push_back(req_step(ACT_LOCATE, 16'sd0, 9'd0));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd0));
		// trigger off: no search, view start stays one screen back
		plan.push_back(cfg_step(CFG_TRIGGER_MODE, 16'(MODE_OFF)));
		plan.push_back(req_step(ACT_LOCATE, 16'sd0, 9'd0));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd506));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd507));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd508));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd509));
		// full gain clamps both ends; zero gain flattens onto the midline
		plan.push_back(cfg_step(CFG_VERTICAL_ZOOM, 16'hFFFF));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd506));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd507));
		plan.push_back(cfg_step(CFG_VERTICAL_ZOOM, 16'd0));
		plan.push_back(req_step(ACT_READ, 16'sd0, 9'd509));
		// mode three acts as falling; zero samples per column acts as one
		plan.push_back(cfg_step(CFG_TRIGGER_MODE, 16'(MODE_FALL_ALT)));
		plan.push_back(cfg_step(CFG_SAMPLES_PER_COLUMN, 16'd0));
		plan.push_back(req_step(ACT_PUSH, 16'sd20000, 9'd0));
		plan.push_back(req_step(ACT_PUSH, 16'sd300, 9'd0));
		plan.push_back(req_step(ACT_PUSH, -16'sd300, 9'd0));
		plan.push_back(req_step(ACT_LOCATE, 16'sd0, 9'd0));

		settings = '{
			'{16'(MODE_RISING),                16'd1,   16'd256},
			'{16'(MODE_FALLING),               16'd3,   16'd4095},
			'{16'(MODE_OFF),                   16'd0,   16'd0},
			'{16'(MODE_FALL_ALT),              16'd2,   16'h0F80},
			'{16'hFFF0 | 16'(MODE_RISING),     16'd5,   16'd1},
			'{16'(MODE_FALLING),               16'd1,   16'hFFFF}
		};

		// hold reset, then release it on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				wait_idle();
				write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				send_request(plan[i].req, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: each one starts idle with a fresh register setting,
		// including both extremes of the mode and zoom registers.
		counted = 0;
		foreach (settings[p]) begin
			wait_idle();
			write_cfg(CFG_TRIGGER_MODE, settings[p].mode);
			write_cfg(CFG_SAMPLES_PER_COLUMN, settings[p].spc);
			write_cfg(CFG_VERTICAL_ZOOM, settings[p].zoom);
			n_settings++;
			wave_step = $urandom_range(300, 9000);
			while (counted < (p + 1) * RANDOM_ITEMS / $size(settings)) begin
				run_sequence(got);
				counted += got;
			end
		end

		// Longest fold: once the column already open closes, a column of 65535 samples
		// stays open through a short stretch of pushes, so no further pair is stored.
		wait_idle();
		write_cfg(CFG_SAMPLES_PER_COLUMN, 16'hFFFF);
		write_cfg(CFG_TRIGGER_MODE, 16'(MODE_RISING));
		n_settings++;
		repeat (40) begin
			r.action       = ACT_PUSH;
			r.sample_value = pick_sample();
			r.column       = COL_W'($urandom);
			send_request(r, 1'b0, '0);
		end
		send_request('{ACT_LOCATE, 16'sd0, 9'd0}, 1'b0, '0);
		send_request('{ACT_READ, 16'sd0, 9'd0}, 1'b0, '0);
		send_request('{ACT_READ, 16'sd0, 9'd511}, 1'b0, '0);

		// drain, then let the block settle before closing out
		req_valid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d pushes into %0d pairs, %0d locates (%0d hits), %0d column reads",
			n_push, n_pairs, n_locate, n_found, n_read);
		$display("%0d ignored requests, %0d register settings, %0d results checked, %0d mismatches",
			n_ignored, n_settings, n_checked, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
